[rtl/ssfm_pkg.sv]
// ----------------------------------------------------------------------------
// ssfm_pkg
// shared types, widths and codes of the first-match substring search
// ----------------------------------------------------------------------------
`default_nettype none

package ssfm_pkg;

    localparam int PATTERN_MAX_DEF     = 16;
    localparam int TEXT_INDEX_BITS_DEF = 16;

    localparam int CHAR_BITS      = 8;
    localparam int LEN_BITS       = 5;
    localparam int POS_BITS       = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [CHAR_BITS-1:0]      char_t;
    typedef logic [LEN_BITS-1:0]       len_t;
    typedef logic [POS_BITS-1:0]       pos_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

    localparam cfg_index_t REG_PATTERN_LENGTH = 2'd0;
    localparam cfg_index_t REG_START_POSITION = 2'd1;

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    // broadcast control from the top-level control logic to every cell
    typedef struct packed {
        logic  shift;
        logic  clear;
        logic  load;
        char_t value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/ssfm_cfg_if.sv]
// ----------------------------------------------------------------------------
// ssfm_cfg_if
// register write channel: index and data with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface ssfm_cfg_if;
    import ssfm_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

`default_nettype wire

[rtl/ssfm_in_if.sv]
// ----------------------------------------------------------------------------
// ssfm_in_if
// input channel: pattern or text byte with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface ssfm_in_if;
    import ssfm_pkg::*;

    logic  valid;
    logic  ready;
    logic  mode;
    char_t char_value;
    logic  end_of_text;

    modport source (output valid, output mode, output char_value, output end_of_text,
                    input ready);
    modport sink (input valid, input mode, input char_value, input end_of_text,
                  output ready);

endinterface

`default_nettype wire

[rtl/ssfm_out_if.sv]
// ----------------------------------------------------------------------------
// ssfm_out_if
// result channel: found flag and match position with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface ssfm_out_if;
    import ssfm_pkg::*;

    logic valid;
    logic ready;
    logic found;
    pos_t match_position;

    modport source (output valid, output found, output match_position, input ready);
    modport sink (input valid, input found, input match_position, output ready);

endinterface

`default_nettype wire

[rtl/ssfm_cell.sv]
// ----------------------------------------------------------------------------
// ssfm_cell
// one window cell: a text byte shifted from its neighbor, one pattern byte,
// and the byte compare for the incoming window
// ----------------------------------------------------------------------------
`default_nettype none

module ssfm_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  ssfm_pkg::cell_ctrl_t ctrl,
    input  wire                 load_sel,
    input  ssfm_pkg::char_t     win_in,
    output ssfm_pkg::char_t     win_out,
    output ssfm_pkg::char_t     pat_out,
    input  ssfm_pkg::char_t     pat_aligned,
    input  wire                 active,
    output logic                hit
);
    import ssfm_pkg::*;

    char_t win_reg;
    char_t win_next;
    char_t pat_reg;

    always_comb
    begin
        win_next = win_reg;
        if (ctrl.clear)
        begin
            win_next = '0;
        end
        else if (ctrl.shift)
        begin
            win_next = win_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load && load_sel)
        begin
            pat_reg <= ctrl.value;
        end
    end

    // compare against the byte entering this cell on the shift
    assign hit     = !active || (win_in == pat_aligned);
    assign win_out = win_reg;
    assign pat_out = pat_reg;

endmodule

`default_nettype wire

[rtl/substring_search_first_match.sv]
// ----------------------------------------------------------------------------
// substring_search_first_match
// first match of a loaded pattern in a streamed text, at or after a start
// position, searched with a row of shifting window cells
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  cfg       in   valid/ready    index, data (pattern_length, start_position)
//  text_in   in   valid/ready    mode, char_value, end_of_text
//  result    out  valid/ready    found, match_position
//
//  one input transaction per cycle; a result appears in the output register
//  the cycle after the text byte that causes it
//  the cell row compares every window byte with the pattern in the same cycle
//  text_in stalls only while a result is held and result.ready is low
//  cfg is always ready; reset clears the window, counters and result valid register
// ----------------------------------------------------------------------------
`default_nettype none

module substring_search_first_match #(
    parameter int PATTERN_MAX     = ssfm_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_INDEX_BITS = ssfm_pkg::TEXT_INDEX_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    ssfm_cfg_if.sink    cfg,
    ssfm_in_if.sink     text_in,
    ssfm_out_if.source  result
);
    import ssfm_pkg::*;

    localparam int FILL_BITS = $clog2(PATTERN_MAX + 1);
    localparam int SH_BITS   = $clog2(PATTERN_MAX + 1);
    localparam int CMPW      = (LEN_BITS > FILL_BITS) ? LEN_BITS : FILL_BITS;
    localparam int CW        = ((TEXT_INDEX_BITS > POS_BITS) ? TEXT_INDEX_BITS : POS_BITS) + 1;
    localparam int FLAT_BITS = PATTERN_MAX * CHAR_BITS;

    len_t                     len_reg;
    pos_t                     start_reg;
    logic [FILL_BITS-1:0]     fill_reg;
    logic [FILL_BITS-1:0]     fill_next;
    logic [TEXT_INDEX_BITS-1:0] idx_reg;
    logic [TEXT_INDEX_BITS-1:0] idx_next;
    logic                     reported_reg;
    logic                     reported_next;
    logic                     res_valid_reg;
    logic                     res_valid_next;
    logic                     found_reg;
    logic                     found_next;
    pos_t                     pos_reg;
    pos_t                     pos_next;

    logic                     cfg_fire;
    logic                     in_fire;
    logic                     text_fire;
    logic                     pat_fire;
    len_t                     ulen;
    logic [SH_BITS-1:0]       sh_amt;
    logic [FLAT_BITS-1:0]     rev_flat;
    logic [FLAT_BITS-1:0]     ap_flat;
    cell_ctrl_t               ctrl;
    char_t                    win_in   [PATTERN_MAX];
    char_t                    win_out  [PATTERN_MAX];
    char_t                    pat_out  [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]   load_sel;
    logic [PATTERN_MAX-1:0]   active;
    logic [PATTERN_MAX-1:0]   hit;
    logic [CW-1:0]            cur_plus1;
    logic [CW-1:0]            begin_pos;
    logic                     enough;
    logic                     begin_ok;
    logic                     match_now;
    logic                     miss_now;

    assign cfg.ready     = 1'b1;
    assign cfg_fire      = cfg.valid && cfg.ready;
    assign text_in.ready = !res_valid_reg || result.ready;
    assign in_fire       = text_in.valid && text_in.ready;
    assign text_fire     = in_fire && (text_in.mode == MODE_TEXT);
    assign pat_fire      = in_fire && (text_in.mode == MODE_PATTERN);

    // pattern length in use, capped at the cell count
    always_comb
    begin
        if (CMPW'(len_reg) > CMPW'(PATTERN_MAX))
        begin
            ulen = LEN_BITS'(PATTERN_MAX);
        end
        else
        begin
            ulen = len_reg;
        end
    end

    assign ctrl.shift = text_fire;
    assign ctrl.clear = text_fire && text_in.end_of_text;
    assign ctrl.load  = pat_fire && (fill_reg < FILL_BITS'(PATTERN_MAX));
    assign ctrl.value = text_in.char_value;

    // align the pattern to the window: cell k sees pattern byte ulen-1-k
    assign sh_amt  = SH_BITS'(PATTERN_MAX) - SH_BITS'(ulen);
    assign ap_flat = rev_flat >> {sh_amt, 3'b000};

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign win_in[k] = text_in.char_value;
            end
            else
            begin : g_link
                assign win_in[k] = win_out[k-1];
            end

            assign rev_flat[k*CHAR_BITS +: CHAR_BITS] = pat_out[PATTERN_MAX-1-k];
            assign load_sel[k] = (fill_reg == FILL_BITS'(k));
            assign active[k]   = (CMPW'(k) < CMPW'(ulen));

            ssfm_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .load_sel    (load_sel[k]),
                .win_in      (win_in[k]),
                .win_out     (win_out[k]),
                .pat_out     (pat_out[k]),
                .pat_aligned (ap_flat[k*CHAR_BITS +: CHAR_BITS]),
                .active      (active[k]),
                .hit         (hit[k])
            );
        end
    endgenerate

    assign cur_plus1 = CW'(idx_reg) + CW'(1);
    assign begin_pos = cur_plus1 - CW'(ulen);
    assign enough    = cur_plus1 >= CW'(ulen);
    assign begin_ok  = begin_pos >= CW'(start_reg);
    assign match_now = text_fire && !reported_reg && (ulen != '0) && enough && begin_ok
                       && (&hit);
    assign miss_now  = text_fire && text_in.end_of_text && !reported_reg && !match_now;

    always_comb
    begin
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        reported_next  = reported_reg;
        res_valid_next = res_valid_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;

        if (cfg_fire && (cfg.index == REG_PATTERN_LENGTH))
        begin
            fill_next = '0;
        end
        else if (ctrl.load)
        begin
            fill_next = fill_reg + FILL_BITS'(1);
        end

        if (text_fire)
        begin
            if (text_in.end_of_text)
            begin
                idx_next      = '0;
                reported_next = 1'b0;
            end
            else
            begin
                if (idx_reg != '1)
                begin
                    idx_next = idx_reg + TEXT_INDEX_BITS'(1);
                end
                if (match_now)
                begin
                    reported_next = 1'b1;
                end
            end
        end

        priority if (match_now)
        begin
            res_valid_next = 1'b1;
            found_next     = 1'b1;
            pos_next       = begin_pos[POS_BITS-1:0];
        end
        else if (miss_now)
        begin
            res_valid_next = 1'b1;
            found_next     = 1'b0;
            pos_next       = '0;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            start_reg     <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            reported_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire && (cfg.index == REG_PATTERN_LENGTH))
            begin
                len_reg <= cfg.data[LEN_BITS-1:0];
            end
            if (cfg_fire && (cfg.index == REG_START_POSITION))
            begin
                start_reg <= cfg.data[POS_BITS-1:0];
            end
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            reported_reg  <= reported_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        pos_reg   <= pos_next;
    end

    assign result.valid          = res_valid_reg;
    assign result.found          = found_reg;
    assign result.match_position = pos_reg;

endmodule

`default_nettype wire

[rtl/ssfm_checker.sv]
// ----------------------------------------------------------------------------
// ssfm_checker
// port-level checks of the substring search, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ssfm_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        cfg_valid,
    input wire        cfg_ready,
    input wire        in_valid,
    input wire        in_ready,
    input wire        in_mode,
    input wire        out_valid,
    input wire        out_ready,
    input wire        out_found,
    input wire [15:0] out_match_position
);
    import ssfm_pkg::*;

    // a held result stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transaction");

    // not-found results carry position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_found |-> out_match_position == '0)
        else $error("not-found result with nonzero position");

    // register writes are never stalled
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("cfg write stalled");

    // a pattern byte never produces a result
    a_pat_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mode == MODE_PATTERN) && !out_valid |=> !out_valid)
        else $error("result after pattern byte");

endmodule

bind substring_search_first_match ssfm_checker u_ssfm_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg.valid),
    .cfg_ready          (cfg.ready),
    .in_valid           (text_in.valid),
    .in_ready           (text_in.ready),
    .in_mode            (text_in.mode),
    .out_valid          (result.valid),
    .out_ready          (result.ready),
    .out_found          (result.found),
    .out_match_position (result.match_position)
);

`default_nettype wire
